@@ hw/rtl/xoshiro256pp_generator_defines.svh @@
// assertion macros shared by the checker
`ifndef XOSHIRO256PP_GENERATOR_DEFINES_SVH
`define XOSHIRO256PP_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define XG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xoshiro256pp_generator: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define XG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xoshiro256pp_generator: next-cycle check failed");

`endif

@@ hw/rtl/xg_pkg.sv @@
package xg_pkg;

	typedef logic [3:0][63:0] xstate_t;

	typedef enum logic [2:0] {
		MODE_SEED    = 3'd0,
		MODE_NEXT    = 3'd1,
		MODE_JUMP    = 3'd2,
		MODE_LONG    = 3'd3,
		MODE_BOUNDED = 3'd4
	} mode_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SMIX = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_POST = 7'b0001000,
		ST_JUMP = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_BCHK = 7'b1000000
	} state_t;

	localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

	// word 0 in the low bits, so the bit index is the step number
	localparam logic [255:0] SHORT_POLY = {64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
	localparam logic [255:0] LONG_POLY = {64'h39109bb02acbe635, 64'h77710069854ee241,
		64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

	function automatic xstate_t xg_advance(input xstate_t w);
		xstate_t r;
		logic [63:0] t;
		t = w[1] << 17;
		r[2] = w[2] ^ w[0];
		r[3] = w[3] ^ w[1];
		r[1] = w[1] ^ r[2];
		r[0] = w[0] ^ r[3];
		r[2] = r[2] ^ t;
		r[3] = {r[3][18:0], r[3][63:19]};
		return r;
	endfunction

	function automatic logic [63:0] xg_scramble(input xstate_t w);
		logic [63:0] sum;
		sum = w[0] + w[3];
		return {sum[40:0], sum[63:41]} + w[0];
	endfunction

endpackage

@@ hw/rtl/xoshiro256pp_generator.sv @@
// xoshiro256++ generator with 256-bit state. A transaction is taken when start is high
// and busy is low; each one gives exactly one result, shown for one cycle with done high,
// and the receiver cannot stall it. A draw leaves busy low, so draws can follow every
// cycle. Seed runs four SplitMix64 steps through one shared 32x32 multiplier, which sums
// four partial products per 64-bit product. Jump and long jump step the state once per
// cycle over the 256 polynomial bits. Bounded mode first finds the rejection threshold
// with a one-bit-per-cycle divider, then checks the caller's product and redraws via
// the multiplier while its low half is below the threshold. A zero limit, an unused mode
// or a draw has done in the next cycle. Reset leaves the state all zero; seed before use.
module xoshiro256pp_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [63:0] seed_value,
	input  logic [63:0] limit,
	input  logic [63:0] product_high,
	input  logic [63:0] product_low,
	output logic        done,
	output logic [63:0] value,
	output logic        bad_limit
);
	import xg_pkg::*;

	state_t       st_q;
	xstate_t      s_q;
	xstate_t      acc_q;
	logic [2:0]   op_q;
	logic [1:0]   k_q;
	logic         phase_q;
	logic [7:0]   cnt_q;
	logic [2:0]   mcnt_q;
	logic [63:0]  sd_q;
	logic [63:0]  ma_q;
	logic [63:0]  mb_q;
	logic [63:0]  pp_q;
	logic [1:0]   sh_q;
	logic [127:0] prod_q;
	logic [63:0]  rem_q;
	logic [63:0]  dvd_q;
	logic [63:0]  thr_q;
	logic [63:0]  lim_q;
	logic [63:0]  hi_q;
	logic [63:0]  lo_q;
	logic         done_q;
	logic [63:0]  value_q;
	logic         bad_q;

	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  mul_p;
	logic [127:0] pp_ext;
	logic [64:0]  div_r;
	logic [63:0]  sd_next;
	logic [63:0]  z;
	logic         poly_bit;

	assign busy      = (st_q != ST_IDLE);
	assign done      = done_q;
	assign value     = value_q;
	assign bad_limit = bad_q;

	assign mul_a    = mcnt_q[0] ? ma_q[63:32] : ma_q[31:0];
	assign mul_b    = mcnt_q[1] ? mb_q[63:32] : mb_q[31:0];
	// 32x32 product, upper operand halves are zero
	assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
	assign div_r    = {rem_q, dvd_q[63]};
	assign sd_next  = sd_q + GOLDEN_STEP;
	assign z        = prod_q[63:0];
	assign poly_bit = (op_q == MODE_LONG) ? LONG_POLY[cnt_q] : SHORT_POLY[cnt_q];

	always_comb begin
		case (sh_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			2'd2:    pp_ext = {pp_q, 64'd0};
			default: pp_ext = 128'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			s_q     <= '0;
			acc_q   <= '0;
			op_q    <= '0;
			k_q     <= '0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			mcnt_q  <= '0;
			sd_q    <= '0;
			ma_q    <= '0;
			mb_q    <= '0;
			pp_q    <= '0;
			sh_q    <= '0;
			prod_q  <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			thr_q   <= '0;
			lim_q   <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
			done_q  <= 1'b0;
			value_q <= '0;
			bad_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= mode;
						case (mode)
							MODE_SEED: begin
								sd_q    <= seed_value;
								k_q     <= 2'd0;
								phase_q <= 1'b0;
								st_q    <= ST_SMIX;
							end
							MODE_NEXT: begin
								value_q <= xg_scramble(s_q);
								bad_q   <= 1'b0;
								done_q  <= 1'b1;
								s_q     <= xg_advance(s_q);
							end
							MODE_JUMP, MODE_LONG: begin
								acc_q <= '0;
								cnt_q <= 8'd0;
								st_q  <= ST_JUMP;
							end
							MODE_BOUNDED: begin
								if (limit == 64'd0) begin
									value_q <= 64'd0;
									bad_q   <= 1'b1;
									done_q  <= 1'b1;
								end else begin
									lim_q <= limit;
									hi_q  <= product_high;
									lo_q  <= product_low;
									dvd_q <= 64'd0 - limit;
									rem_q <= 64'd0;
									cnt_q <= 8'd0;
									st_q  <= ST_DIV;
								end
							end
							default: begin
								value_q <= 64'd0;
								bad_q   <= 1'b0;
								done_q  <= 1'b1;
							end
						endcase
					end
				end
				ST_SMIX: begin
					sd_q   <= sd_next;
					ma_q   <= sd_next ^ (sd_next >> 30);
					mb_q   <= MIX_MUL_A;
					mcnt_q <= 3'd0;
					prod_q <= '0;
					st_q   <= ST_MUL;
				end
				ST_MUL: begin
					// partial product registered, then added in the next cycle
					if (mcnt_q != 3'd4) begin
						pp_q <= mul_p;
						sh_q <= 2'({1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]});
					end
					if (mcnt_q != 3'd0)
						prod_q <= prod_q + pp_ext;
					if (mcnt_q == 3'd4)
						st_q <= ST_POST;
					mcnt_q <= mcnt_q + 3'd1;
				end
				ST_POST: begin
					if (op_q == MODE_SEED) begin
						if (!phase_q) begin
							ma_q    <= z ^ (z >> 27);
							mb_q    <= MIX_MUL_B;
							phase_q <= 1'b1;
							mcnt_q  <= 3'd0;
							prod_q  <= '0;
							st_q    <= ST_MUL;
						end else begin
							s_q[k_q] <= z ^ (z >> 31);
							phase_q  <= 1'b0;
							k_q      <= k_q + 2'd1;
							if (k_q == 2'd3) begin
								value_q <= 64'd0;
								bad_q   <= 1'b0;
								done_q  <= 1'b1;
								st_q    <= ST_IDLE;
							end else begin
								st_q <= ST_SMIX;
							end
						end
					end else begin
						hi_q <= prod_q[127:64];
						lo_q <= prod_q[63:0];
						st_q <= ST_BCHK;
					end
				end
				ST_JUMP: begin
					if (cnt_q == 8'd255) begin
						s_q     <= poly_bit ? (acc_q ^ s_q) : acc_q;
						value_q <= 64'd0;
						bad_q   <= 1'b0;
						done_q  <= 1'b1;
						st_q    <= ST_IDLE;
					end else begin
						if (poly_bit)
							acc_q <= acc_q ^ s_q;
						s_q   <= xg_advance(s_q);
						cnt_q <= cnt_q + 8'd1;
					end
				end
				ST_DIV: begin
					// restoring division of (2^64 - limit) by limit, remainder only
					if (div_r >= {1'b0, lim_q})
						rem_q <= 64'(div_r - {1'b0, lim_q});
					else
						rem_q <= div_r[63:0];
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q[5:0] == 6'd63) begin
						thr_q <= (div_r >= {1'b0, lim_q}) ? 64'(div_r - {1'b0, lim_q})
							: div_r[63:0];
						st_q  <= ST_BCHK;
					end
				end
				ST_BCHK: begin
					if (lo_q < thr_q) begin
						if (s_q == '0) begin
							// unseeded state would redraw forever
							value_q <= 64'd0;
							bad_q   <= 1'b0;
							done_q  <= 1'b1;
							st_q    <= ST_IDLE;
						end else begin
							ma_q   <= xg_scramble(s_q);
							mb_q   <= lim_q;
							s_q    <= xg_advance(s_q);
							mcnt_q <= 3'd0;
							prod_q <= '0;
							st_q   <= ST_MUL;
						end
					end else begin
						value_q <= hi_q;
						bad_q   <= 1'b0;
						done_q  <= 1'b1;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/xg_checker.sv @@
`include "xoshiro256pp_generator_defines.svh"

module xg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  mode,
	input logic [63:0] limit,
	input logic        done,
	input logic [63:0] value,
	input logic        bad_limit
);
	import xg_pkg::*;

	`XG_ASSERT_NOW(a_done_idle, done, !busy)
	`XG_ASSERT_NOW(a_bad_zero, done && bad_limit, value == 64'd0)
	`XG_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)
	`XG_ASSERT_NEXT(a_draw_fast, start && !busy && mode == MODE_NEXT, done && !busy && !bad_limit)
	`XG_ASSERT_NEXT(a_zero_limit, start && !busy && mode == MODE_BOUNDED && limit == 64'd0,
		done && bad_limit)

endmodule

bind xoshiro256pp_generator xg_checker u_xg_checker (.*);
